// ----- rtl/sfsd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfsd_pkg
// Shared constants, codes and tables of the full-step stepper driver.
// ----------------------------------------------------------------------------
package sfsd_pkg;

  // Input item kinds
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // Register map (word index)
  localparam logic REG_START_INTERVAL = 1'b0;

  localparam int          PENDING_LIMIT_DEF  = 32767;
  localparam int          PENDING_RST        = 100;
  localparam logic [15:0] START_INTERVAL_RST = 16'd890;
  localparam logic [2:0]  RAMP_LAST_STAGE    = 3'd5;
  localparam logic [7:0]  FWD_MAX            = 8'd127;

  // Q16 interval factor per ramp stage; unity once the ramp has settled
  function automatic logic [16:0] ramp_factor(input logic [2:0] stage);
    logic [16:0] f;
    case (stage)
      3'd0:    f = 17'd63570;
      3'd1:    f = 17'd64750;
      3'd2:    f = 17'd65221;
      3'd3:    f = 17'd65410;
      3'd4:    f = 17'd65486;
      default: f = 17'd65536;
    endcase
    return f;
  endfunction

  // Full-step coil pattern: A+B, B+C, C+D, D+A
  function automatic logic [3:0] phase_pattern(input logic [1:0] phase);
    logic [3:0] p;
    case (phase)
      2'd0:    p = 4'h3;
      2'd1:    p = 4'h6;
      2'd2:    p = 4'hC;
      default: p = 4'h9;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/sfsd_ramp.sv -----
// ----------------------------------------------------------------------------
// sfsd_ramp
// Next step interval: interval scaled by the stage's Q16 factor, floored at 1.
// ----------------------------------------------------------------------------
module sfsd_ramp
  import sfsd_pkg::*;
(
  input  logic [15:0] interval,
  input  logic [2:0]  stage,
  output logic [15:0] interval_next
);

  logic [32:0] product;
  logic [16:0] scaled;

  assign product = {17'b0, interval} * {16'b0, ramp_factor(stage)};
  assign scaled  = product[32:16];

  // Factor never exceeds unity, so the scaled value fits in 16 bits
  assign interval_next = (scaled == 17'd0) ? 16'd1 : scaled[15:0];

endmodule

// ----- rtl/stepper_full_step_driver_unit.sv -----
// ----------------------------------------------------------------------------
// stepper_full_step_driver_unit
// Four-coil full-step stepper driver with an accelerating step ramp.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless the output stalls; the state update and
//   ramp multiply sit between the two registers. A stalled output holds the
//   input stage.
// Reset: pending count 100, phase 0, coils off, ramp stage 0, countdown 0,
//   start interval 890.
module stepper_full_step_driver_unit
  import sfsd_pkg::*;
#(
  parameter int PENDING_LIMIT = PENDING_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] cmd_byte
  input  logic        s_tuser,   // [0] cmd
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [3:0] coils, [4] stepped, [20:5] pending,
                                 // [21] saturated, [23:22] zero
);

  localparam int PW = $clog2(longint'(PENDING_LIMIT) + 1) + 1;
  localparam logic signed [PW:0]   LIM     = (PW+1)'(PENDING_LIMIT);
  localparam logic signed [PW-1:0] PEND_RV = PW'(PENDING_RST);

  // Configuration register
  logic [15:0] start_interval;
  logic [15:0] start_eff;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_interval <= START_INTERVAL_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_START_INTERVAL)) begin
      start_interval <= pwdata[15:0];
    end
  end

  assign prdata    = (paddr[2] == REG_START_INTERVAL) ? {16'b0, start_interval} : 32'b0;
  assign start_eff = (start_interval == 16'd0) ? 16'd1 : start_interval;

  // Input register
  logic       in_valid;
  logic       in_cmd;
  logic [7:0] in_byte;
  logic       adv;
  logic       fire;

  assign adv      = !m_tvalid || m_tready;
  assign fire     = in_valid && adv;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  // Driver state
  logic signed [PW-1:0] pending_steps, pending_steps_next;
  logic [1:0]           coil_phase, coil_phase_next;
  logic [15:0]          step_interval, step_interval_next;
  logic [2:0]           ramp_stage, ramp_stage_next;
  logic [15:0]          tick_countdown, tick_countdown_next;
  logic [3:0]           coil_drive, coil_drive_next;
  logic                 stepped, sat;

  logic [15:0]          ramp_interval;
  logic signed [8:0]    delta;
  logic signed [PW:0]   sum;
  logic [PW+15:0]       pend_wide;

  sfsd_ramp u_ramp (
    .interval      (step_interval),
    .stage         (ramp_stage),
    .interval_next (ramp_interval)
  );

  assign delta = (in_byte > FWD_MAX) ? -$signed({1'b0, in_byte - FWD_MAX})
                                     : $signed({1'b0, in_byte});
  assign sum   = {pending_steps[PW-1], pending_steps} + (PW+1)'(delta);

  always_comb begin
    pending_steps_next  = pending_steps;
    coil_phase_next     = coil_phase;
    step_interval_next  = step_interval;
    ramp_stage_next     = ramp_stage;
    tick_countdown_next = tick_countdown;
    coil_drive_next     = coil_drive;
    stepped             = 1'b0;
    sat                 = 1'b0;
    if (in_cmd == CMD_BYTE) begin
      if (in_byte != 8'd0) begin
        if (sum > LIM) begin
          pending_steps_next = PW'(LIM);
          sat                = 1'b1;
        end else if (sum < -LIM) begin
          pending_steps_next = PW'(-LIM);
          sat                = 1'b1;
        end else begin
          pending_steps_next = sum[PW-1:0];
        end
      end
    end else if (tick_countdown != 16'd0) begin
      tick_countdown_next = tick_countdown - 16'd1;
    end else if (pending_steps != '0) begin
      coil_drive_next = phase_pattern(coil_phase);
      if (pending_steps > 0) begin
        coil_phase_next    = coil_phase + 2'd1;
        pending_steps_next = pending_steps - PW'(1);
      end else begin
        coil_phase_next    = coil_phase - 2'd1;
        pending_steps_next = pending_steps + PW'(1);
      end
      stepped             = 1'b1;
      tick_countdown_next = step_interval - 16'd1;
      step_interval_next  = ramp_interval;
      if (ramp_stage < RAMP_LAST_STAGE) begin
        ramp_stage_next = ramp_stage + 3'd1;
      end
    end else begin
      // idle: coils off, restart the ramp
      coil_drive_next    = 4'h0;
      step_interval_next = start_eff;
      ramp_stage_next    = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_steps  <= PEND_RV;
      coil_phase     <= 2'd0;
      step_interval  <= START_INTERVAL_RST;
      ramp_stage     <= 3'd0;
      tick_countdown <= 16'd0;
      coil_drive     <= 4'h0;
    end else if (fire) begin
      pending_steps  <= pending_steps_next;
      coil_phase     <= coil_phase_next;
      step_interval  <= step_interval_next;
      ramp_stage     <= ramp_stage_next;
      tick_countdown <= tick_countdown_next;
      coil_drive     <= coil_drive_next;
    end
  end

  // Result register
  assign pend_wide = {{16{pending_steps_next[PW-1]}}, pending_steps_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {2'b00, sat, pend_wide[15:0], stepped, coil_drive_next};
    end
  end

`ifndef SYNTHESIS
  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    (pending_steps <= $signed(LIM[PW-1:0]) && pending_steps >= -$signed(LIM[PW-1:0])))
    else $error("pending count outside its limit");

  a_interval_nonzero: assert property (@(posedge clk) disable iff (rst)
    step_interval != 16'd0)
    else $error("step interval reached zero");

  a_stage_range: assert property (@(posedge clk) disable iff (rst)
    ramp_stage <= RAMP_LAST_STAGE)
    else $error("ramp stage beyond last stage");

  a_step_coils: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> ($countones(m_tdata[3:0]) == 2))
    else $error("step taken without a two-coil pattern");

  a_countdown_no_step: assert property (@(posedge clk) disable iff (rst)
    (fire && in_cmd == CMD_TICK && tick_countdown != 16'd0) |=> !m_tdata[4])
    else $error("step taken during countdown");
`endif

endmodule

// ----- test/tb_stepper_full_step_driver_unit.sv -----
// ----------------------------------------------------------------------------
// tb_stepper_full_step_driver_unit
// Self-checking bench for the full-step stepper driver: tick and command
// items stream in with random bursts and gaps, the result stream stalls on
// its own pattern, and every result is checked against a cycle-free
// predictor of pending count, coil drive, phase and step ramp.
// ----------------------------------------------------------------------------
module tb_stepper_full_step_driver_unit;
  import sfsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_START_INTERVAL = 3'(REG_START_INTERVAL) << 2;
  localparam logic [2:0] ADDR_UNMAPPED       = 3'd4;
  localparam logic [7:0] BYTE_NOP            = 8'd0;
  localparam logic [7:0] REV_MIN             = 8'd128;
  localparam logic [7:0] REV_MAX             = 8'd255;
  localparam int         PHASE_ITEMS         = 40;

  typedef struct {
    logic [3:0]  coils;
    logic        stepped;
    logic [15:0] pending;
    logic        saturated;
  } drive_word_t;

  typedef enum logic [1:0] {RX_OPEN, RX_THREE_IN_FOUR, RX_COIN, RX_ALTERNATE} rx_mode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] cmd_byte
  logic        s_tuser  = 1'b0; // [0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [3:0] coils, [4] stepped, [20:5] pending,
                                // [21] saturated, [23:22] zero

  // Predicted driver state
  logic [15:0] start_cfg  = START_INTERVAL_RST;
  int          pend_cnt   = PENDING_RST;
  logic [1:0]  phase_q    = '0;
  logic [15:0] intv       = START_INTERVAL_RST;
  logic [2:0]  stage_q    = '0;
  logic [15:0] cdown      = '0;
  logic [3:0]  coil_q     = '0;

  drive_word_t drive_due[$];
  drive_word_t want_w;

  int unsigned burst_left = 0;
  int unsigned n_errors   = 0;
  int unsigned n_results  = 0;
  int unsigned n_ticks    = 0;
  int unsigned n_cmds     = 0;
  int unsigned n_steps    = 0;
  int unsigned n_sat      = 0;
  int unsigned n_restarts = 0;
  logic [6:0]  rx_age     = '0;
  rx_mode_t    rx_mode    = RX_OPEN;

  stepper_full_step_driver_unit dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata
  );

  always #5 clk = ~clk;

  function automatic logic [16:0] ramp_q16(input logic [2:0] stage);
    case (stage)
      3'd0:    return 17'd63570;
      3'd1:    return 17'd64750;
      3'd2:    return 17'd65221;
      3'd3:    return 17'd65410;
      3'd4:    return 17'd65486;
      default: return 17'd65536;
    endcase
  endfunction

  function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
    case (phase)
      2'd0:    return 4'b0011;
      2'd1:    return 4'b0110;
      2'd2:    return 4'b1100;
      default: return 4'b1001;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= 30)
      $display("[%0t] result %0d: %s got 0x%0h want 0x%0h", $realtime, n_results,
               what, got, want);
  endtask

  // Advance the predicted state by one accepted item and queue its result
  task automatic predict_drive(input logic kind, input logic [7:0] b);
    drive_word_t r;
    int          v;
    logic [32:0] prod;
    logic [16:0] nxt;
    r = '{coils: '0, stepped: 1'b0, pending: '0, saturated: 1'b0};
    if (kind == CMD_BYTE) begin
      n_cmds++;
      if (b != BYTE_NOP) begin
        v = pend_cnt;
        if (b > FWD_MAX) v = v - (int'(b) - int'(FWD_MAX));
        else v = v + int'(b);
        if (v > PENDING_LIMIT_DEF) begin
          v = PENDING_LIMIT_DEF;
          r.saturated = 1'b1;
        end else if (v < -PENDING_LIMIT_DEF) begin
          v = -PENDING_LIMIT_DEF;
          r.saturated = 1'b1;
        end
        if (r.saturated) n_sat++;
        pend_cnt = v;
      end
    end else begin
      n_ticks++;
      if (cdown != 0) begin
        cdown = cdown - 16'd1;
      end else if (pend_cnt != 0) begin
        coil_q = coil_pattern(phase_q);
        if (pend_cnt > 0) begin
          phase_q  = phase_q + 2'd1;
          pend_cnt = pend_cnt - 1;
        end else begin
          phase_q  = phase_q - 2'd1;
          pend_cnt = pend_cnt + 1;
        end
        r.stepped = 1'b1;
        n_steps++;
        cdown = intv - 16'd1;
        prod  = 33'(intv) * 33'(ramp_q16(stage_q));
        nxt   = prod[32:16];
        intv  = (nxt == 0) ? 16'd1 : nxt[15:0];
        if (stage_q < RAMP_LAST_STAGE) stage_q = stage_q + 3'd1;
      end else begin
        coil_q  = '0;
        intv    = (start_cfg == 0) ? 16'd1 : start_cfg;
        stage_q = '0;
        n_restarts++;
      end
    end
    r.coils   = coil_q;
    r.pending = pend_cnt[15:0];
    drive_due.push_back(r);
  endtask

  // Send one item; entered and left just after a rising edge
  task automatic send_item(input logic kind, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    predict_drive(kind, b);
  endtask

  task automatic send_tick;
    send_item(CMD_TICK, 8'($urandom));
  endtask

  // Hold the sender until every result is in, then let the pipeline empty
  task automatic wait_drain;
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (drive_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_START_INTERVAL) start_cfg = data[15:0];
    @(posedge clk);
  endtask

  task automatic check_register;
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_START_INTERVAL;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[15:0] !== start_cfg) report_mismatch("start_interval readback", got, start_cfg);
    @(posedge clk);
  endtask

  // Cancel whatever is pending with command items only
  task automatic zero_pending;
    while (pend_cnt != 0) begin
      if (pend_cnt > int'(REV_MIN)) send_item(CMD_BYTE, REV_MAX);
      else if (pend_cnt > 0) send_item(CMD_BYTE, FWD_MAX + 8'(pend_cnt));
      else if (pend_cnt < -int'(FWD_MAX)) send_item(CMD_BYTE, FWD_MAX);
      else send_item(CMD_BYTE, 8'(-pend_cnt));
    end
  endtask

  // Run the countdown out and restart the ramp so the block is truly idle
  task automatic settle_idle;
    zero_pending();
    while (cdown != 0) send_tick();
    send_tick();
    wait_drain();
  endtask

  // A short move: a small command, then roughly enough ticks to finish it
  task automatic run_move;
    int unsigned c;
    int unsigned n;
    int unsigned s;
    logic [7:0]  b;
    c = $urandom_range(1, 6);
    s = (start_cfg == 0) ? 1 : start_cfg;
    b = $urandom_range(0, 1) ? 8'(c) : FWD_MAX + 8'(c);
    if ($urandom_range(0, 9) == 0) b = 8'($urandom);
    send_item(CMD_BYTE, b);
    n = $urandom_range(c * s / 2, c * s + 8);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0)
        send_item(CMD_BYTE, $urandom_range(0, 1) ? 8'($urandom_range(1, 3))
                                                  : 8'($urandom_range(128, 130)));
      else
        send_tick();
    end
    if ($urandom_range(0, 7) == 0) wait_drain();
  endtask

  task automatic test_register_access;
    check_register();
    write_reg(ADDR_START_INTERVAL, {16'hA5C3, 16'd0});
    check_register();
    write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    check_register();
  endtask

  // Extremes of the command byte, zero start interval, reversal and no-op
  task automatic test_directed;
    send_item(CMD_BYTE, BYTE_NOP);
    send_item(CMD_BYTE, FWD_MAX + 8'd100);
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_BYTE, 8'd1);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_BYTE, FWD_MAX);
    repeat (3) send_tick();
    send_item(CMD_BYTE, REV_MAX);
    repeat (6) send_tick();
    send_item(CMD_BYTE, REV_MIN);
    repeat (2) send_tick();
    send_item(CMD_BYTE, 8'h55);
    send_item(CMD_BYTE, 8'hAA);
    send_item(CMD_TICK, 8'h00);
  endtask

  // Walk the pending count onto both limits and past them
  task automatic test_saturation;
    zero_pending();
    repeat (PENDING_LIMIT_DEF / int'(FWD_MAX)) send_item(CMD_BYTE, FWD_MAX);
    while (pend_cnt < PENDING_LIMIT_DEF) send_item(CMD_BYTE, 8'd1);
    send_item(CMD_BYTE, 8'd1);
    send_item(CMD_BYTE, FWD_MAX);
    repeat (2) send_tick();
    while (pend_cnt > -PENDING_LIMIT_DEF) send_item(CMD_BYTE, REV_MAX);
    send_item(CMD_BYTE, REV_MAX);
    send_item(CMD_BYTE, REV_MIN);
    repeat (2) send_tick();
    zero_pending();
  endtask

  task automatic test_random_ramps;
    logic [15:0] starts[5];
    int unsigned first;
    starts = '{16'd1, 16'd2, 16'd3, 16'd6, 16'($urandom_range(4, 12))};
    foreach (starts[i]) begin
      settle_idle();
      write_reg(ADDR_START_INTERVAL, {16'($urandom), starts[i]});
      check_register();
      first = n_ticks + n_cmds;
      while (n_ticks + n_cmds - first < PHASE_ITEMS) run_move();
    end
  endtask

  // Largest start interval: one step at the top of the ramp, then a few
  // countdown ticks and a no-op command
  task automatic test_long_interval;
    settle_idle();
    write_reg(ADDR_START_INTERVAL, 32'h0000_FFFF);
    check_register();
    send_tick();
    send_item(CMD_BYTE, 8'd2);
    send_tick();
    repeat (6) send_tick();
    send_item(CMD_BYTE, BYTE_NOP);
    repeat (3) send_tick();
  endtask

  // Result check and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (drive_due.size() == 0) begin
          report_mismatch("unexpected result", 32'(m_tdata), 32'd0);
        end else begin
          want_w = drive_due.pop_front();
          if (m_tdata[3:0] !== want_w.coils)
            report_mismatch("coils", 32'(m_tdata[3:0]), 32'(want_w.coils));
          if (m_tdata[4] !== want_w.stepped)
            report_mismatch("stepped", 32'(m_tdata[4]), 32'(want_w.stepped));
          if (m_tdata[20:5] !== want_w.pending)
            report_mismatch("pending", 32'(m_tdata[20:5]), 32'(want_w.pending));
          if (m_tdata[21] !== want_w.saturated)
            report_mismatch("saturated", 32'(m_tdata[21]), 32'(want_w.saturated));
        end
        n_results++;
      end
      rx_age <= rx_age + 7'd1;
      if (rx_age == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:          m_tready <= 1'b1;
        RX_THREE_IN_FOUR: m_tready <= (rx_age[1:0] != 2'd3);
        RX_COIN:          m_tready <= 1'($urandom_range(0, 1));
        default:          m_tready <= rx_age[0];
      endcase
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_directed();
    test_saturation();
    test_random_ramps();
    test_long_interval();
    wait_drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d ticks and %0d commands: %0d steps, %0d ramp restarts,",
             n_ticks, n_cmds, n_steps, n_restarts);
    $display("%0d saturating commands, start intervals from 0 to 65535.", n_sat);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sfsd_pkg.sv
rtl/sfsd_ramp.sv
rtl/stepper_full_step_driver_unit.sv
test/tb_stepper_full_step_driver_unit.sv
